### src/pcwa_pkg.sv
package pcwa_pkg;

    // Fixed field widths of the item formats.
    localparam int CH_W    = 6;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;

    // Operation codes carried in the op field of an input item.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [CH_W-1:0]           chan_id;
        logic signed [VALUE_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [VALUE_W-1:0] average;
        logic                      empty_res;
        logic                      last;
    } out_item_t;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        logic                      flush;
        logic [CH_W-1:0]           id;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

### src/per_channel_window_averager_unit.sv
// Per-channel window averager.
// Input channel item_valid / item_stall / item carries one item per handshake:
// op add adds sample_value (signed Q16.16) to the sum of channel chan_id and
// raises its count (dropped once the count saturates); op flush walks every
// channel seen since reset in ascending order, reports sum/count truncated
// toward zero, then clears that channel's sum and count.
// Output channel result_valid / result_stall / result carries one item per
// reported channel; last marks the final item of a flush, empty_res a channel
// with no samples in the window. A flush with no channel seen gives nothing.
// The back end handles a sample as a read-modify-write of the table memory.
// A flush skips unseen channels, reads and clears each seen one and averages
// those with samples on the 48-step one-bit-per-cycle divider. A two-entry
// command queue decouples the input.
// Reset clears the seen flags; an unseen entry reads as zero, so there is no
// clearing pass and the block takes items right after reset.
// A stalled receiver holds the output register; the flush walk then waits
// with up to two further results held inside, one queued and one just
// computed.
module per_channel_window_averager_unit #(
    parameter int NUM_CHANNELS = 64,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  pcwa_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output pcwa_pkg::out_item_t result
);

    // Only 64 channels can be addressed by the six-bit chan_id, so the
    // tables never need more entries than that.
    localparam int TABLE_DEPTH = (NUM_CHANNELS < 64) ? NUM_CHANNELS : 64;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    pcwa_pkg::cmd_t q_in;
    pcwa_pkg::cmd_t q_head;

    // The front end classifies items and drops out-of-range samples.
    pcwa_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .q_full     (q_full),
        .push       (q_push),
        .cmd        (q_in)
    );

    pcwa_fifo #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // The back end owns the tables, the divider and the output register.
    pcwa_back #(
        .DEPTH       (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### src/pcwa_ram.sv
module pcwa_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/pcwa_fifo.sv
module pcwa_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcwa_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output pcwa_pkg::cmd_t head,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcwa_pkg::cmd_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/pcwa_front.sv
module pcwa_front #(
    parameter int NUM_CHANNELS = 64
) (
    input  logic               item_valid,
    input  pcwa_pkg::in_item_t item,
    output logic               item_stall,
    input  logic               q_full,
    output logic               push,
    output pcwa_pkg::cmd_t     cmd
);

    logic in_range;
    logic is_flush;

    // Samples for channels that have no table entry are swallowed here.
    assign in_range   = (int'(item.chan_id) < NUM_CHANNELS);
    assign is_flush   = (item.op == pcwa_pkg::OP_FLUSH);
    assign item_stall = q_full;
    assign push       = item_valid && !q_full && (is_flush || in_range);

    assign cmd.flush = is_flush;
    assign cmd.id    = item.chan_id;
    assign cmd.value = item.sample_value;

endmodule

### src/pcwa_div.sv
module pcwa_div #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [pcwa_pkg::SUM_W-1:0]         dividend,
    input  logic [COUNT_WIDTH-1:0]             divisor,
    output logic                               busy,
    output logic                               done,
    output logic signed [pcwa_pkg::VALUE_W-1:0] quotient
);

    localparam int SW     = pcwa_pkg::SUM_W;
    localparam int VW     = pcwa_pkg::VALUE_W;
    localparam int STEP_W = $clog2(SW);
    localparam logic [SW-1:0] POS_LIMIT = SW'({1'b0, {(VW - 1){1'b1}}});
    localparam logic [SW-1:0] NEG_LIMIT = SW'({1'b1, {(VW - 1){1'b0}}});

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [SW-1:0]          quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_WIDTH:0]   rem_shift;
    logic [COUNT_WIDTH:0]   rem_diff;
    logic                   ge;
    logic [SW-1:0]          neg_mag;

    // One quotient bit per cycle, restoring division on magnitudes.
    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign ge        = (rem_shift >= {1'b0, dvs_reg});
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign neg_mag   = -quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SW-1];
            quo_next  = dividend[SW-1] ? -dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(SW - 1);
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SW-2:0], ge};
            rem_next = ge ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
        end
    end

    // Apply the sign and clamp to the 32-bit range.
    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (quo_reg > NEG_LIMIT) ? NEG_LIMIT[VW-1:0] : neg_mag[VW-1:0];
        end
        else
        begin
            quotient = (quo_reg > POS_LIMIT) ? POS_LIMIT[VW-1:0] : quo_reg[VW-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### src/pcwa_back.sv
module pcwa_back #(
    parameter int DEPTH       = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  pcwa_pkg::cmd_t      q_head,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output pcwa_pkg::out_item_t result
);

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW      = pcwa_pkg::SUM_W;
    localparam int VW      = pcwa_pkg::VALUE_W;
    localparam int ENTRY_W = SW + COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FETCH,
        S_DIV,
        S_PUSH,
        S_END
    } state_t;

    state_t              state_reg, state_next;
    pcwa_pkg::cmd_t      cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [DEPTH-1:0]    seen_reg, seen_next;
    pcwa_pkg::out_item_t res_reg, res_next;
    pcwa_pkg::out_item_t pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    pcwa_pkg::out_item_t result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [SW-1:0]          rd_sum;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [SW-1:0]          cur_sum;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [ADDR_W-1:0]      cmd_addr;
    logic                   out_free;
    logic                   last_idx;

    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic signed [VW-1:0]        div_quotient;

    pcwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcwa_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_sum),
        .divisor  (rd_cnt),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rd_sum   = ram_rdata[ENTRY_W-1 -: SW];
    assign rd_cnt   = ram_rdata[COUNT_WIDTH-1:0];
    assign cmd_addr = cmd_reg.id[ADDR_W-1:0];
    assign out_free = !result_valid_reg || !result_stall;
    assign last_idx = (idx_reg == ADDR_W'(DEPTH - 1));

    // An entry never touched since reset reads as zero sum and zero count.
    assign cur_sum = seen_reg[cmd_addr] ? rd_sum : '0;
    assign cur_cnt = seen_reg[cmd_addr] ? rd_cnt : '0;

    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign ram_raddr = (state_reg == S_SCAN) ? idx_reg : q_head.id[ADDR_W-1:0];
    assign div_start = (state_reg == S_FETCH) && (rd_cnt != '0);

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        idx_next          = idx_reg;
        seen_next         = seen_reg;
        res_next          = res_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        ram_we            = 1'b0;
        ram_waddr         = cmd_addr;
        ram_wdata         = {cur_sum + {{(SW - VW){cmd_reg.value[VW-1]}}, cmd_reg.value},
                             cur_cnt + 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    cmd_next   = q_head;
                    idx_next   = '0;
                    state_next = q_head.flush ? S_SCAN : S_ADD;
                end
            end
            S_ADD:
            begin
                seen_next[cmd_addr] = 1'b1;
                ram_we              = (cur_cnt != '1);
                state_next          = S_IDLE;
            end
            S_SCAN:
            begin
                if (seen_reg[idx_reg])
                begin
                    state_next = S_FETCH;
                end
                else if (last_idx)
                begin
                    state_next = S_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                res_next.channel   = pcwa_pkg::CH_W'(idx_reg);
                res_next.average   = '0;
                res_next.empty_res = 1'b1;
                res_next.last      = 1'b0;
                state_next = (rd_cnt == '0) ? S_PUSH : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.average   = div_quotient;
                    res_next.empty_res = 1'b0;
                    state_next         = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // The previous result leaves only once a later one exists,
                // so that the final one can carry the last flag.
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        result_next       = pend_reg;
                        result_valid_next = 1'b1;
                    end
                    pend_next       = res_reg;
                    pend_valid_next = 1'b1;
                    if (last_idx)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    result_next       = pend_reg;
                    result_next.last  = 1'b1;
                    result_valid_next = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= '0;
            idx_reg          <= '0;
            seen_reg         <= '0;
            res_reg          <= '0;
            pend_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            idx_reg          <= idx_next;
            seen_reg         <= seen_next;
            res_reg          <= res_next;
            pend_reg         <= pend_next;
            pend_valid_reg   <= pend_valid_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    a_add_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |=> (state_reg == S_IDLE))
        else $error("sample update did not return to idle");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind after a flush");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

### verif/tb_per_channel_window_averager_unit.sv
module tb_per_channel_window_averager_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default size; the predictor mirrors it.
    localparam int NUM_CH   = 64;
    localparam int CNT_W    = 16;

    // Run shape. Even if every item were a flush averaging all 64 channels
    // against the longest receiver stalls, a correct run would stay well under
    // the cycle limit below.
    localparam longint CYCLE_LIMIT  = 10_000_000;
    localparam int     RANDOM_ITEMS = 430;
    localparam int     CALM_TAIL    = 60;
    localparam int     END_SETTLE   = 500;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    pcwa_pkg::in_item_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    pcwa_pkg::out_item_t result;

    per_channel_window_averager_unit #(
        .NUM_CHANNELS (NUM_CH),
        .COUNT_WIDTH  (CNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The scoreboard keeps its own copy of the channel tables. Every accepted
    // input item is applied to that copy, and a flush turns into the list of
    // window means that the block must return, in the order it returns them.
    class channel_mean_board;
        logic [pcwa_pkg::SUM_W-1:0] sums   [NUM_CH];
        logic [CNT_W-1:0]           counts [NUM_CH];
        bit                         seen   [NUM_CH];
        pcwa_pkg::out_item_t        pending_means [$];
        int                         errors;

        function new();
            foreach (sums[ch])
            begin
                sums[ch]   = '0;
                counts[ch] = '0;
                seen[ch]   = 1'b0;
            end
            errors = 0;
        endfunction

        // Truncating division of the 48-bit signed sum, clamped to 32 bits.
        function logic [pcwa_pkg::VALUE_W-1:0] window_mean(
            logic [pcwa_pkg::SUM_W-1:0] total,
            logic [CNT_W-1:0]           n);
            logic signed [pcwa_pkg::SUM_W-1:0] total_s;
            longint                            q;
            total_s = total;
            q = longint'(total_s) / longint'(n);
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            return q[pcwa_pkg::VALUE_W-1:0];
        endfunction

        function void note_item(pcwa_pkg::in_item_t it);
            pcwa_pkg::out_item_t r;
            int                  top_seen;
            if (it.op == pcwa_pkg::OP_ADD)
            begin
                if (int'(it.chan_id) < NUM_CH)
                begin
                    seen[it.chan_id] = 1'b1;
                    // A saturated count drops the sample altogether.
                    if (counts[it.chan_id] != '1)
                    begin
                        sums[it.chan_id]   = sums[it.chan_id]
                            + {{(pcwa_pkg::SUM_W-pcwa_pkg::VALUE_W)
                                {it.sample_value[pcwa_pkg::VALUE_W-1]}},
                               it.sample_value};
                        counts[it.chan_id] = counts[it.chan_id] + 1'b1;
                    end
                end
                return;
            end
            // The last flag goes on the highest channel seen so far.
            top_seen = -1;
            for (int ch = 0; ch < NUM_CH; ch++)
                if (seen[ch])
                    top_seen = ch;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (!seen[ch])
                    continue;
                r.channel = pcwa_pkg::CH_W'(ch);
                if (counts[ch] == '0)
                begin
                    r.average   = '0;
                    r.empty_res = 1'b1;
                end
                else
                begin
                    r.average   = window_mean(sums[ch], counts[ch]);
                    r.empty_res = 1'b0;
                end
                r.last = (ch == top_seen);
                pending_means.push_back(r);
                sums[ch]   = '0;
                counts[ch] = '0;
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(pcwa_pkg::out_item_t got);
            pcwa_pkg::out_item_t want;
            if (pending_means.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result for channel %0d",
                                          got.channel));
                return;
            end
            want = pending_means.pop_front();
            if (got.channel !== want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d",
                                          got.channel, want.channel));
            if (got.average !== want.average)
                report_mismatch($sformatf("channel %0d average %h, expected %h",
                                          want.channel, got.average, want.average));
            if (got.empty_res !== want.empty_res)
                report_mismatch($sformatf("channel %0d empty_res %b, expected %b",
                                          want.channel, got.empty_res,
                                          want.empty_res));
            if (got.last !== want.last)
                report_mismatch($sformatf("channel %0d last %b, expected %b",
                                          want.channel, got.last, want.last));
        endtask

        function int outstanding();
            return pending_means.size();
        endfunction
    endclass

    channel_mean_board board;

    // Idling on both sides is switched off for the final stretch of the run.
    bit     idling_on = 1'b0;
    int     tx_calm   = 0;
    int     rx_calm   = 0;
    int     rx_stall_left = 0;
    longint cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a run that hangs anywhere ends here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[per_channel_window_averager_unit] ERROR");
        $finish;
    end

    // Receiver. Outputs are sampled in the active region just after the
    // edge, so they still hold what the block presented before it, and the
    // stall for the next cycle is then driven with a nonblocking assignment.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
        if (!idling_on)
        begin
            rx_stall_left = 0;
            result_stall <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            result_stall <= 1'b1;
        end
        else if (rx_calm > 0)
        begin
            rx_calm--;
            result_stall <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    rx_stall_left = $urandom_range(1, 19) - 1;
                    result_stall <= 1'b1;
                end
                3:
                begin
                    rx_calm = $urandom_range(20, 200);
                    result_stall <= 1'b0;
                end
                default: result_stall <= 1'b0;
            endcase
        end
    end

    function automatic pcwa_pkg::in_item_t sample_item(
        int id, logic [pcwa_pkg::VALUE_W-1:0] v);
        pcwa_pkg::in_item_t it;
        it.op           = pcwa_pkg::OP_ADD;
        it.chan_id      = pcwa_pkg::CH_W'(id);
        it.sample_value = v;
        return it;
    endfunction

    // The channel and value fields of a flush carry noise; the block must
    // ignore them.
    function automatic pcwa_pkg::in_item_t flush_item();
        pcwa_pkg::in_item_t it;
        it.op           = pcwa_pkg::OP_FLUSH;
        it.chan_id      = pcwa_pkg::CH_W'($urandom);
        it.sample_value = $urandom;
        return it;
    endfunction

    function automatic logic [pcwa_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return int'($urandom_range(0, 2000)) - 1000;
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            4:       return int'($urandom_range(0, 1 << 24)) - (1 << 23);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Presents one item and holds it until the block takes it. Called at a
    // rising edge; returns at the edge where the item was accepted.
    task automatic send_item(input pcwa_pkg::in_item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        board.note_item(it);
    endtask

    // Random gap after an item, with calm stretches in which none occurs.
    task automatic sender_gap();
        int n;
        if (!idling_on)
            return;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            tx_calm = $urandom_range(10, 40);
            return;
        end
        if ($urandom_range(0, 99) < 30)
        begin
            n = $urandom_range(1, 19);
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // The sender holds back until every expected result has come.
    task automatic wait_for_results();
        if (board.outstanding() == 0)
            return;
        item_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic send_directed(input pcwa_pkg::in_item_t it);
        send_item(it);
        sender_gap();
    endtask

    initial
    begin
        int hot_base;
        bit hot_mode;
        board = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling_on = 1'b1;

        // A flush before any channel has been seen must give nothing.
        send_directed(flush_item());
        // Largest positive value: the sum of two leaves the 32-bit range, yet the mean is exact.
        send_directed(sample_item(0, 32'h7FFF_FFFF));
        send_directed(sample_item(0, 32'h0000_0001));
        // Most negative values on the top channel.
        send_directed(sample_item(63, 32'h8000_0000));
        send_directed(sample_item(63, 32'h8000_0000));
        // Negative quotients truncate toward zero, positive ones downwards.
        send_directed(sample_item(5, 32'hFFFF_FFFD));
        send_directed(sample_item(5, 32'h0000_0000));
        send_directed(sample_item(10, 32'h0000_0007));
        send_directed(sample_item(10, 32'h0000_0000));
        send_directed(sample_item(10, 32'h0000_0000));
        send_directed(sample_item(20, 32'hFFFF_FFF9));
        send_directed(sample_item(20, 32'h0000_0000));
        send_directed(sample_item(20, 32'h0000_0000));
        // A zero mean is not the same as an empty channel.
        send_directed(sample_item(31, 32'h0000_0000));
        send_directed(sample_item(42, 32'hFFFF_FFFF));
        send_directed(flush_item());
        // Straight after a flush every seen channel is empty.
        send_directed(flush_item());
        send_directed(sample_item(42, 32'h0001_8000));
        send_directed(sample_item(42, 32'hFFFF_0000));
        send_directed(flush_item());

        wait_for_results();

        // Random part. Channels are sometimes drawn from a small group so
        // that windows hold several samples; flushes come now and then,
        // sometimes twice in a row to give empty channels.
        hot_mode  = 1'b0;
        hot_base  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_TAIL)
                idling_on = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            if (n % 50 == 0)
            begin
                hot_mode = $urandom_range(0, 1);
                hot_base = 8 * $urandom_range(0, 7);
            end
            if ($urandom_range(0, 99) < 8)
            begin
                send_item(flush_item());
                if ($urandom_range(0, 3) == 0)
                    send_item(flush_item());
            end
            else if (hot_mode)
                send_item(sample_item(hot_base + $urandom_range(0, 7), random_value()));
            else
                send_item(sample_item($urandom_range(0, 63), random_value()));
            sender_gap();
        end
        send_item(flush_item());

        item_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        if (board.errors == 0)
            $display("[per_channel_window_averager_unit] OK");
        else
            $display("[per_channel_window_averager_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/pcwa_pkg.sv
src/pcwa_ram.sv
src/pcwa_fifo.sv
src/pcwa_front.sv
src/pcwa_div.sv
src/pcwa_back.sv
src/per_channel_window_averager_unit.sv
verif/tb_per_channel_window_averager_unit.sv
